// ===== sv/dcp_pkg.sv =====
`timescale 1ns / 1ps

package dcp_pkg;

  // default number of fraction digits carried in the scaled values
  localparam int FRACTION_DIGITS_DEF = 6;

  // saturation limit of every scaled value
  localparam logic [29:0] VALUE_MAX = 30'd999999999;

  // special characters of the coordinate text
  localparam logic [7:0] CH_DEGREE = 8'hB0;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;

  typedef enum logic [1:0] {
    KIND_UNKNOWN = 2'd0,
    KIND_LAT     = 2'd1,
    KIND_LON     = 2'd2
  } dcp_kind_e;

  // input transaction payload
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
    logic [1:0] kind_hint;
  } dcp_in_t;

  // output transaction payload
  typedef struct packed {
    logic signed [30:0] degrees_scaled;
    logic [29:0]        minutes_scaled;
    logic [29:0]        seconds_scaled;
    logic [1:0]         coord_kind;
    logic               parsed_ok;
  } dcp_out_t;

  // running parse state of one string
  typedef struct packed {
    logic [2:0][29:0] fields;
    logic [29:0]      cur_num;
    logic [1:0]       field_idx;
    logic [3:0]       frac_pos;
    logic             in_num;
    logic             neg;
    logic             parsed;
    logic             frozen;
    dcp_kind_e        kind;
  } dcp_state_t;

  localparam dcp_state_t DCP_STATE_RESET = '0;

  // ten to the n, n up to 6
  function automatic logic [19:0] pow10(input logic [2:0] n);
    logic [19:0] v;
    case (n)
      3'd0:    v = 20'd1;
      3'd1:    v = 20'd10;
      3'd2:    v = 20'd100;
      3'd3:    v = 20'd1000;
      3'd4:    v = 20'd10000;
      3'd5:    v = 20'd100000;
      3'd6:    v = 20'd1000000;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/dcp_char_step.sv =====
`timescale 1ns / 1ps

module dcp_char_step import dcp_pkg::*; #(
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
  input  dcp_state_t state_i,
  input  logic [7:0] char_i,
  output dcp_state_t state_o
);

  localparam logic [19:0] Scale = pow10(3'(FRACTION_DIGITS));

  logic [3:0]  digit;
  logic [3:0]  wexp;
  logic [19:0] weight;
  logic [33:0] cur_ext;
  logic [33:0] int_sum;
  logic [33:0] frac_sum;
  logic [33:0] acc;
  logic [29:0] cur_new;
  logic [1:0]  slot;

  // digit arithmetic
  always_comb begin
    digit    = char_i[3:0];
    wexp     = 4'(FRACTION_DIGITS) - state_i.frac_pos;
    weight   = (state_i.frac_pos <= 4'(FRACTION_DIGITS)) ? pow10(wexp[2:0]) : 20'd0;
    cur_ext  = {4'b0, state_i.cur_num};
    int_sum  = (cur_ext << 3) + (cur_ext << 1) + 34'(digit) * 34'(Scale);
    frac_sum = cur_ext + 34'(digit) * 34'(weight);
    acc      = (state_i.frac_pos == 4'd0) ? int_sum : frac_sum;
    cur_new  = (acc > 34'(VALUE_MAX)) ? VALUE_MAX : acc[29:0];
    slot     = (state_i.field_idx > 2'd2) ? 2'd2 : state_i.field_idx;
  end

  always_comb begin
    state_o = state_i;
    if (!state_i.frozen) begin
      if (char_i inside {[8'h30:8'h39]}) begin
        state_o.in_num = 1'b1;
        if (state_i.frac_pos != 4'd0 && state_i.frac_pos != 4'd15) begin
          state_o.frac_pos = state_i.frac_pos + 4'd1;
        end
        state_o.cur_num      = cur_new;
        state_o.fields[slot] = cur_new;
      end else begin
        case (char_i)
          "W", "w", "S", "s", "N", "n", "E", "e": begin
            state_o.neg      = (char_i == "W") || (char_i == "w") ||
                               (char_i == "S") || (char_i == "s");
            state_o.kind     = ((char_i == "S") || (char_i == "s") ||
                                (char_i == "N") || (char_i == "n")) ? KIND_LAT : KIND_LON;
            state_o.in_num   = 1'b0;
            state_o.frac_pos = 4'd0;
            state_o.parsed   = 1'b1;
            state_o.frozen   = 1'b1;
          end
          CH_DEGREE, CH_QUOTE, CH_DQUOTE: begin
            if (char_i == CH_DEGREE) begin
              state_o.fields[0] = state_i.cur_num;
              state_o.field_idx = 2'd1;
            end else if (char_i == CH_QUOTE) begin
              state_o.fields[1] = state_i.cur_num;
              state_o.field_idx = 2'd2;
            end else begin
              state_o.fields[2] = state_i.cur_num;
              state_o.field_idx = slot;
            end
            if (state_i.in_num) state_o.parsed = 1'b1;
            state_o.in_num   = 1'b0;
            state_o.cur_num  = '0;
            state_o.frac_pos = 4'd0;
          end
          CH_DOT:   state_o.frac_pos = 4'd1;
          CH_MINUS: state_o.neg = 1'b1;
          CH_PLUS:  state_o.neg = 1'b0;
          default: begin
            // separator: other letters only close the number
            state_o.frac_pos = 4'd0;
            state_o.cur_num  = '0;
            state_o.in_num   = 1'b0;
            if (state_i.in_num && !(char_i inside {[8'h41:8'h5A], [8'h61:8'h7A]}) &&
                state_i.field_idx < 2'd2) begin
              state_o.field_idx = state_i.field_idx + 2'd1;
            end
          end
        endcase
      end
    end
  end

endmodule

// ===== sv/dms_coordinate_text_parser.sv =====
`timescale 1ns / 1ps

// Degrees-minutes-seconds coordinate text parser. Feed the text one byte per
// transaction, with last_char set on the final byte; one result transaction
// follows each final byte and the parser then starts clean for the next string.
// Degrees, minutes and seconds come out scaled by ten to FRACTION_DIGITS and
// saturate at 999999999; degrees are negated for a minus sign, S or W. A
// hemisphere letter fixes the kind and ignores the rest of the string; the
// degree (0xB0), minute and second marks close a field. Throughput is one byte
// per cycle, set by the per-character update of the parse state; only a final
// byte can wait, while an earlier string still fills the snapshot stage and the
// output is stalled. A final byte passes the input register, the character
// update into the snapshot, then result formatting into the output register.
module dms_coordinate_text_parser import dcp_pkg::*; #(
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dcp_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dcp_out_t out_data_o
);

  localparam logic [19:0] Scale    = pow10(3'(FRACTION_DIGITS));
  localparam logic [29:0] DegLimit = 30'(90 * Scale);

  // snapshot of a finished string, waiting for formatting
  typedef struct packed {
    logic [2:0][29:0] fields;
    logic             neg;
    dcp_kind_e        kind;
    logic             parsed;
    logic [1:0]       hint;
  } dcp_snap_t;

  // input register
  logic       inp_vld_q, inp_vld_d;
  dcp_in_t    inp_q;

  // parse state
  dcp_state_t st_q, st_step;

  // snapshot stage
  logic       snap_vld_q, snap_vld_d;
  dcp_snap_t  snap_q;

  // output register
  logic       out_vld_q, out_vld_d;
  dcp_out_t   out_q, out_d;

  logic       out_free;
  logic       snap_adv;
  logic       proc_en;
  logic       in_accept;

  // pipeline flow control, each stage moves when the one after it has room
  assign out_free   = !out_vld_q || out_ready_i;
  assign snap_adv   = snap_vld_q && out_free;
  assign proc_en    = inp_vld_q && (!inp_q.last_char || !snap_vld_q || out_free);
  assign in_ready_o = !inp_vld_q || proc_en;
  assign in_accept  = in_valid_i && in_ready_o;

  assign inp_vld_d  = in_accept ? 1'b1 : (proc_en ? 1'b0 : inp_vld_q);
  assign snap_vld_d = (proc_en && inp_q.last_char) ? 1'b1 : (snap_adv ? 1'b0 : snap_vld_q);
  assign out_vld_d  = snap_adv ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);

  // per-character update of the parse state
  dcp_char_step #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_step (
    .state_i(st_q),
    .char_i (inp_q.char_code),
    .state_o(st_step)
  );

  // result formatting: kind selection, longitude override and sign
  always_comb begin
    dcp_kind_e kind;
    if (snap_q.kind != KIND_UNKNOWN) begin
      kind = snap_q.kind;
    end else if (snap_q.hint == 2'd3) begin
      kind = KIND_UNKNOWN;
    end else begin
      kind = dcp_kind_e'(snap_q.hint);
    end
    // more than ninety degrees can only be a longitude
    if (snap_q.fields[0] > DegLimit) kind = KIND_LON;
    out_d.degrees_scaled = snap_q.neg ? (31'sd0 - $signed({1'b0, snap_q.fields[0]}))
                                      : $signed({1'b0, snap_q.fields[0]});
    out_d.minutes_scaled = snap_q.fields[1];
    out_d.seconds_scaled = snap_q.fields[2];
    out_d.coord_kind     = kind;
    out_d.parsed_ok      = snap_q.parsed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inp_vld_q  <= 1'b0;
      snap_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      st_q       <= DCP_STATE_RESET;
    end else begin
      inp_vld_q  <= inp_vld_d;
      snap_vld_q <= snap_vld_d;
      out_vld_q  <= out_vld_d;
      if (proc_en) begin
        // the final byte hands the string over and clears the state
        st_q <= inp_q.last_char ? DCP_STATE_RESET : st_step;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) inp_q <= in_data_i;
    if (proc_en && inp_q.last_char) begin
      snap_q.fields <= st_step.fields;
      snap_q.neg    <= st_step.neg;
      snap_q.kind   <= st_step.kind;
      snap_q.parsed <= st_step.parsed;
      snap_q.hint   <= inp_q.kind_hint;
    end
    if (snap_adv) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/dcp_checker.sv =====
`timescale 1ns / 1ps

module dcp_checker import dcp_pkg::*; #(
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input dcp_out_t out_data_o
);

  localparam logic signed [31:0] DegLimit = 32'(90 * pow10(3'(FRACTION_DIGITS)));

  // result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // with room at the output the parser always takes a byte
  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("parser stalled although output has room");

  // beyond ninety degrees the kind is longitude
  a_lon_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((32'(out_data_o.degrees_scaled) > DegLimit) ||
                    (32'(out_data_o.degrees_scaled) < -DegLimit))
    |-> out_data_o.coord_kind == KIND_LON)
    else $error("large degrees not reported as longitude");

endmodule

bind dms_coordinate_text_parser dcp_checker #(
  .FRACTION_DIGITS(FRACTION_DIGITS)
) u_dcp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
